[rtl/mmrm_pkg.sv]
// Shared widths, codes, types and the memory type classifier of the region merger.
`default_nettype none

package mmrm_pkg;

  localparam int KERNEL_SLOTS = 8;
  localparam int PAGE_SHIFT   = 12;

  localparam int KIDX_W  = (KERNEL_SLOTS > 1) ? $clog2(KERNEL_SLOTS) : 1;
  localparam int KCNT_W  = $clog2(KERNEL_SLOTS + 1);
  localparam int ADDR_W  = 64;
  localparam int PAGES_W = 52;
  localparam int TYPE_W  = 32;
  localparam int CLS_W   = 4;
  localparam int CNT_W   = 16;
  localparam int ST_W    = 2;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CNT_W-1:0] ENTRY_LIMIT_RESET = 16'd256;
  localparam logic             REG_ENTRY_LIMIT   = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_DESC = 2'd1,
    CMD_END  = 2'd2
  } command_t;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [ST_W-1:0] ST_UNPLACED = 2'd2;

  localparam logic [CLS_W-1:0] CLS_UNUSABLE = 4'd0;
  localparam logic [CLS_W-1:0] CLS_USABLE   = 4'd1;
  localparam logic [CLS_W-1:0] CLS_RESERVED = 4'd2;
  localparam logic [CLS_W-1:0] CLS_ACPI     = 4'd3;
  localparam logic [CLS_W-1:0] CLS_ACPI_NVS = 4'd4;
  localparam logic [CLS_W-1:0] CLS_MMIO     = 4'd5;
  localparam logic [CLS_W-1:0] CLS_RT_CODE  = 4'd6;
  localparam logic [CLS_W-1:0] CLS_RT_DATA  = 4'd7;
  localparam logic [CLS_W-1:0] CLS_UNKNOWN  = 4'd8;
  localparam logic [CLS_W-1:0] CLS_KCODE    = 4'd9;
  localparam logic [CLS_W-1:0] CLS_KDATA    = 4'd10;

  // firmware memory type codes
  localparam logic [TYPE_W-1:0] MT_RESERVED     = 32'd0;
  localparam logic [TYPE_W-1:0] MT_LOADER_CODE  = 32'd1;
  localparam logic [TYPE_W-1:0] MT_LOADER_DATA  = 32'd2;
  localparam logic [TYPE_W-1:0] MT_BS_CODE      = 32'd3;
  localparam logic [TYPE_W-1:0] MT_BS_DATA      = 32'd4;
  localparam logic [TYPE_W-1:0] MT_RT_CODE      = 32'd5;
  localparam logic [TYPE_W-1:0] MT_RT_DATA      = 32'd6;
  localparam logic [TYPE_W-1:0] MT_CONVENTIONAL = 32'd7;
  localparam logic [TYPE_W-1:0] MT_UNUSABLE     = 32'd8;
  localparam logic [TYPE_W-1:0] MT_ACPI_RECLAIM = 32'd9;
  localparam logic [TYPE_W-1:0] MT_ACPI_NVS     = 32'd10;
  localparam logic [TYPE_W-1:0] MT_MMIO         = 32'd11;
  localparam logic [TYPE_W-1:0] MT_MMIO_PORT    = 32'd12;
  localparam logic [TYPE_W-1:0] MT_PAL_CODE     = 32'd13;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_PEND,
    EMIT_KERN,
    EMIT_SUMM
  } emit_sel_t;

  typedef struct packed {
    logic      accept;
    logic      calc;
    emit_sel_t emit;
    logic      set_err;
    logic      merge;
    logic      open;
    logic      push_last;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic rem_zero;
    logic have_kernel;
    logic fit;
    logic pend_valid;
    logic cls_match;
    logic room_ok;
    logic emit_ok;
    logic hold_valid;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] bytes;
    logic              summ;
    logic [ST_W-1:0]   status;
    logic [CNT_W-1:0]  total;
    logic [ADDR_W-1:0] mem;
  } res_t;

  function automatic logic [CLS_W-1:0] class_of(input logic [TYPE_W-1:0] t);
    logic [CLS_W-1:0] c;
    unique case (t)
      MT_UNUSABLE:                                   c = CLS_UNUSABLE;
      MT_LOADER_CODE, MT_LOADER_DATA, MT_BS_CODE,
      MT_BS_DATA, MT_CONVENTIONAL:                   c = CLS_USABLE;
      MT_PAL_CODE, MT_MMIO_PORT, MT_RESERVED:        c = CLS_RESERVED;
      MT_ACPI_RECLAIM:                               c = CLS_ACPI;
      MT_ACPI_NVS:                                   c = CLS_ACPI_NVS;
      MT_MMIO:                                       c = CLS_MMIO;
      MT_RT_CODE:                                    c = CLS_RT_CODE;
      MT_RT_DATA:                                    c = CLS_RT_DATA;
      default:                                       c = CLS_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/mmrm_in_if.sv]
// Input channel: kernel runs, firmware descriptors and end-of-map beats.
`default_nettype none

interface mmrm_in_if
  import mmrm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [TYPE_W-1:0]  memory_type;
  logic [ADDR_W-1:0]  start_address;
  logic [PAGES_W-1:0] page_count;
  logic               executable;

  modport source (
    output valid, command, memory_type, start_address, page_count, executable,
    input  ready
  );
  modport sink (
    input  valid, command, memory_type, start_address, page_count, executable,
    output ready
  );
endinterface

`default_nettype wire

[rtl/mmrm_out_if.sv]
// Output channel: map entries and the end summary.
`default_nettype none

interface mmrm_out_if
  import mmrm_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CLS_W-1:0]  region_class;
  logic [ADDR_W-1:0] region_base;
  logic [ADDR_W-1:0] region_bytes;
  logic              is_summary;
  logic [ST_W-1:0]   status;
  logic [CNT_W-1:0]  entry_total;
  logic [ADDR_W-1:0] memory_bytes;
  logic              last;

  modport source (
    output valid, region_class, region_base, region_bytes, is_summary, status,
           entry_total, memory_bytes, last,
    input  ready
  );
  modport sink (
    input  valid, region_class, region_base, region_bytes, is_summary, status,
           entry_total, memory_bytes, last,
    output ready
  );
endinterface

`default_nettype wire

[rtl/mmrm_ctrl.sv]
// Sequencer for the region merger: walks kernel runs and orders emits.
`default_nettype none

module mmrm_ctrl
  import mmrm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_command,
  output logic            in_ready,
  input  wire status_t    st,
  output cmd_t            cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_SUM    = 11'b000_0000_0010,
    S_FIT    = 11'b000_0000_0100,
    S_KFLUSH = 11'b000_0000_1000,
    S_KROOM  = 11'b000_0001_0000,
    S_REM    = 11'b000_0010_0000,
    S_RFLUSH = 11'b000_0100_0000,
    S_ROPEN  = 11'b000_1000_0000,
    S_EFLUSH = 11'b001_0000_0000,
    S_ESUM   = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_command == CMD_DESC) begin
            state_next = S_SUM;
          end else if (in_command == CMD_END) begin
            state_next = S_EFLUSH;
          end
        end
      end
      S_SUM: begin
        // sticky overflow drops the whole descriptor
        if (st.err) begin
          state_next = S_DONE;
        end else if (!st.rem_zero && st.have_kernel) begin
          cmd.calc   = 1'b1;
          state_next = S_FIT;
        end else begin
          state_next = S_REM;
        end
      end
      S_FIT: begin
        state_next = st.fit ? S_KFLUSH : S_REM;
      end
      S_KFLUSH: begin
        if (!st.pend_valid) begin
          state_next = S_KROOM;
        end else if (st.emit_ok) begin
          cmd.emit   = EMIT_PEND;
          state_next = S_KROOM;
        end
      end
      S_KROOM: begin
        if (!st.room_ok) begin
          cmd.set_err = 1'b1;
          state_next  = S_DONE;
        end else if (st.emit_ok) begin
          cmd.emit   = EMIT_KERN;
          state_next = S_SUM;
        end
      end
      S_REM: begin
        if (st.rem_zero) begin
          state_next = S_DONE;
        end else if (st.pend_valid && st.cls_match) begin
          cmd.merge  = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_RFLUSH;
        end
      end
      S_RFLUSH: begin
        if (!st.pend_valid) begin
          state_next = S_ROPEN;
        end else if (st.emit_ok) begin
          cmd.emit   = EMIT_PEND;
          state_next = S_ROPEN;
        end
      end
      S_ROPEN: begin
        if (st.room_ok) begin
          cmd.open = 1'b1;
        end else begin
          cmd.set_err = 1'b1;
        end
        state_next = S_DONE;
      end
      S_EFLUSH: begin
        if (!st.pend_valid) begin
          state_next = S_ESUM;
        end else if (st.emit_ok) begin
          cmd.emit   = EMIT_PEND;
          state_next = S_ESUM;
        end
      end
      S_ESUM: begin
        if (st.emit_ok) begin
          cmd.emit   = EMIT_SUMM;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // the held beat is the item's final one
        if (!st.hold_valid) begin
          state_next = S_IDLE;
        end else if (st.out_free) begin
          cmd.push_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_idle_hold_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !st.hold_valid)
    else $error("held beat left over while idle");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit != EMIT_NONE) |-> st.emit_ok)
    else $error("emit issued with no room downstream");

  a_push_last: assert property (@(posedge clk) disable iff (rst)
    cmd.push_last |-> (st.hold_valid && st.out_free))
    else $error("final push without a held beat or free output");

endmodule

`default_nettype wire

[rtl/mmrm_dpath.sv]
// Datapath: kernel run table, pending entry, counters, span check, output stages.
`default_nettype none

module mmrm_dpath
  import mmrm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output status_t                 st,
  input  wire logic [1:0]         in_command,
  input  wire logic [TYPE_W-1:0]  in_memory_type,
  input  wire logic [ADDR_W-1:0]  in_start_address,
  input  wire logic [PAGES_W-1:0] in_page_count,
  input  wire logic               in_executable,
  input  wire logic [CNT_W-1:0]   entry_limit,
  mmrm_out_if.source              region
);

  logic [ADDR_W-1:0]  kernel_start [KERNEL_SLOTS];
  logic [PAGES_W-1:0] kernel_pages [KERNEL_SLOTS];
  logic               kernel_exec  [KERNEL_SLOTS];
  logic [KCNT_W-1:0]  kernel_loaded;
  logic [KCNT_W-1:0]  kernel_next;

  logic              pending_valid;
  logic [CLS_W-1:0]  pending_class;
  logic [ADDR_W-1:0] pending_base;
  logic [ADDR_W-1:0] pending_bytes;
  logic [CNT_W-1:0]  entries_made;
  logic [ADDR_W-1:0] bytes_total;
  logic [ST_W-1:0]   error_code;

  logic [CLS_W-1:0]  cur_cls;
  logic [ADDR_W-1:0] cur_start;
  logic [ADDR_W-1:0] rem;
  logic [ADDR_W-1:0] kend;
  logic [ADDR_W-1:0] dend;
  logic              ks_ge;

  logic hold_valid;
  res_t hold;
  logic out_valid;
  res_t out_res;
  logic out_last;

  logic [KIDX_W-1:0] kidx;
  logic [ADDR_W-1:0] ks;
  logic [ADDR_W-1:0] kb;
  logic [ADDR_W-1:0] db;
  logic              have_kernel;
  logic              err;
  logic              out_free;
  logic              push_out;
  logic              emit;
  logic              table_wr;
  res_t              new_res;
  logic [ST_W-1:0]   summ_status;

  assign kidx        = kernel_next[KIDX_W-1:0];
  assign ks          = kernel_start[kidx];
  assign kb          = ADDR_W'(kernel_pages[kidx]) << PAGE_SHIFT;
  assign db          = rem << PAGE_SHIFT;
  assign have_kernel = (kernel_next < kernel_loaded);
  assign err         = (error_code == ST_OVERFLOW);
  assign out_free    = !out_valid || region.ready;
  assign emit        = (cmd.emit != EMIT_NONE);
  assign push_out    = (emit && hold_valid) || cmd.push_last;
  assign table_wr    = cmd.accept && (in_command == CMD_LOAD) &&
                       (kernel_loaded < KCNT_W'(KERNEL_SLOTS));
  assign summ_status = err ? ST_OVERFLOW : (have_kernel ? ST_UNPLACED : ST_OK);

  always_comb begin
    new_res = '0;
    unique case (cmd.emit)
      EMIT_PEND: begin
        new_res.cls    = pending_class;
        new_res.base   = pending_base;
        new_res.bytes  = pending_bytes;
        new_res.status = error_code;
      end
      EMIT_KERN: begin
        new_res.cls    = kernel_exec[kidx] ? CLS_KCODE : CLS_KDATA;
        new_res.base   = ks;
        new_res.bytes  = kb;
        new_res.status = error_code;
      end
      EMIT_SUMM: begin
        new_res.summ   = 1'b1;
        new_res.status = summ_status;
        new_res.total  = entries_made;
        new_res.mem    = bytes_total;
      end
      default: begin
        new_res = '0;
      end
    endcase
  end

  always_comb begin
    st             = '0;
    st.err         = err;
    st.rem_zero    = (rem == '0);
    st.have_kernel = have_kernel;
    st.fit         = ks_ge && (kend <= dend);
    st.pend_valid  = pending_valid;
    st.cls_match   = (pending_class == cur_cls);
    st.room_ok     = (entries_made < entry_limit);
    st.emit_ok     = !hold_valid || out_free;
    st.hold_valid  = hold_valid;
    st.out_free    = out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_loaded <= '0;
      kernel_next   <= '0;
      pending_valid <= 1'b0;
      entries_made  <= '0;
      bytes_total   <= '0;
      error_code    <= ST_OK;
      hold_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (table_wr) begin
        kernel_loaded <= kernel_loaded + 1'b1;
      end
      if (cmd.set_err) begin
        error_code <= ST_OVERFLOW;
      end
      if (cmd.merge) begin
        bytes_total <= bytes_total + db;
      end
      if (cmd.open) begin
        pending_valid <= 1'b1;
        entries_made  <= entries_made + 1'b1;
        bytes_total   <= bytes_total + db;
      end
      unique case (cmd.emit)
        EMIT_PEND: begin
          pending_valid <= 1'b0;
        end
        EMIT_KERN: begin
          kernel_next  <= kernel_next + 1'b1;
          entries_made <= entries_made + 1'b1;
          bytes_total  <= bytes_total + kb;
        end
        EMIT_SUMM: begin
          kernel_loaded <= '0;
          kernel_next   <= '0;
          pending_valid <= 1'b0;
          entries_made  <= '0;
          bytes_total   <= '0;
          error_code    <= ST_OK;
        end
        default: begin
        end
      endcase
      if (emit) begin
        hold_valid <= 1'b1;
      end else if (cmd.push_last) begin
        hold_valid <= 1'b0;
      end
      if (push_out) begin
        out_valid <= 1'b1;
      end else if (region.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (table_wr) begin
      kernel_start[kernel_loaded[KIDX_W-1:0]] <= in_start_address;
      kernel_pages[kernel_loaded[KIDX_W-1:0]] <= in_page_count;
      kernel_exec[kernel_loaded[KIDX_W-1:0]]  <= in_executable;
    end
    if (cmd.accept) begin
      cur_cls   <= class_of(in_memory_type);
      cur_start <= in_start_address;
      rem       <= ADDR_W'(in_page_count);
    end
    if (cmd.calc) begin
      // span check uses the descriptor's original start
      kend  <= ks + kb;
      dend  <= cur_start + db;
      ks_ge <= (ks >= cur_start);
    end
    if (cmd.emit == EMIT_KERN) begin
      rem <= rem - ADDR_W'(kernel_pages[kidx]);
    end
    if (cmd.merge) begin
      pending_bytes <= pending_bytes + db;
    end
    if (cmd.open) begin
      pending_class <= cur_cls;
      pending_base  <= cur_start;
      pending_bytes <= db;
    end
    if (emit) begin
      hold <= new_res;
    end
    if (push_out) begin
      out_res  <= hold;
      out_last <= cmd.push_last;
    end
  end

  assign region.valid        = out_valid;
  assign region.region_class = out_res.cls;
  assign region.region_base  = out_res.base;
  assign region.region_bytes = out_res.bytes;
  assign region.is_summary   = out_res.summ;
  assign region.status       = out_res.status;
  assign region.entry_total  = out_res.total;
  assign region.memory_bytes = out_res.mem;
  assign region.last         = out_last;

  a_next_le_loaded: assert property (@(posedge clk) disable iff (rst)
    kernel_next <= kernel_loaded)
    else $error("kernel run cursor passed the loaded count");

  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push_out |-> out_free)
    else $error("output register overwritten before it was taken");

  a_open_no_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.open |-> !pending_valid)
    else $error("new entry opened over a live pending entry");

endmodule

`default_nettype wire

[rtl/memory_map_region_merger.sv]
// Top level of the memory map region merger: register port and block wiring.
//
//   channel  dir  beat / access
//   desc     in   command, memory_type, start_address, page_count, executable
//   region   out  region_class, region_base, region_bytes, is_summary, status,
//                 entry_total, memory_bytes, last
//   apb      cfg  entry_limit at byte address 0, 32-bit data
//
// One item at a time. A kernel run load or an unknown command is taken in idle; the end beat
// flushes the pending entry, then the summary. A descriptor is dropped once overflow is set;
// else it places each fitting run (span sum, compare, flush, emit), then merges or opens.
// Output beats leave through a one-deep hold and an output register, so a
// stalled sink only holds the sequencer once both are full.
// Synchronous active-high reset clears all counters and flags; no sweep.
`default_nettype none

module memory_map_region_merger
  import mmrm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  mmrm_in_if.sink                desc,
  mmrm_out_if.source             region
);

  logic [CNT_W-1:0] entry_limit;
  logic             in_ready;
  cmd_t             cmd;
  status_t          st;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[APB_AW-1:2] == REG_ENTRY_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= ENTRY_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      entry_limit <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DW'(entry_limit) : '0;

  assign desc.ready = in_ready;

  mmrm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (desc.valid),
    .in_command (desc.command),
    .in_ready   (in_ready),
    .st         (st),
    .cmd        (cmd)
  );

  mmrm_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .in_command       (desc.command),
    .in_memory_type   (desc.memory_type),
    .in_start_address (desc.start_address),
    .in_page_count    (desc.page_count),
    .in_executable    (desc.executable),
    .entry_limit      (entry_limit),
    .region           (region)
  );

endmodule

`default_nettype wire
